// ===== hw/rtl/pbosc_pkg.sv =====
// Shared constants, types and the sine lookup table of the polyBLEP oscillator.
`timescale 1ns / 1ps
package pbosc_pkg;

	localparam int TABLE_BITS  = 11;
	localparam int FRAC_BITS   = 16;
	localparam int SAMPLE_BITS = 16;

	localparam int PH_BITS = TABLE_BITS + FRAC_BITS;
	localparam int SFRAC   = SAMPLE_BITS - 1;
	localparam int TQ      = 24;
	localparam int QW      = TQ + 1;
	localparam int CNT_W   = $clog2(TQ + 1);
	localparam int SW      = SFRAC + 3;
	localparam int MW      = 28;
	localparam int PW      = 2 * MW;
	localparam int ACC_W   = 40;
	localparam int QA_W    = TABLE_BITS - 1;
	localparam int HALF    = 1 << (TABLE_BITS - 1);
	localparam int QUARTER = HALF >> 1;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 27;
	localparam int RATIO_W    = 18;
	localparam int GAIN_W     = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_THR    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_OFFSET = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SAW_GAIN     = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_GAIN   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SUB_GAIN     = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DETUNE_RATIO = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SUB_RATIO    = 4'd7;

	// wave modes
	localparam logic [1:0] MODE_SINE    = 2'd0;
	localparam logic [1:0] MODE_SAW     = 2'd1;
	localparam logic [1:0] MODE_PULSE   = 2'd2;
	localparam logic [1:0] MODE_EXTREME = 2'd3;

	// saw jobs
	localparam logic [1:0] JOB_MAIN   = 2'd0;
	localparam logic [1:0] JOB_SHIFT  = 2'd1;
	localparam logic [1:0] JOB_DETUNE = 2'd2;
	localparam logic [1:0] JOB_SUB    = 2'd3;

	// multiplier operand selects
	localparam logic [2:0] MS_DET  = 3'd0;
	localparam logic [2:0] MS_SUB  = 3'd1;
	localparam logic [2:0] MS_SQR  = 3'd2;
	localparam logic [2:0] MS_MIX0 = 3'd3;
	localparam logic [2:0] MS_MIX1 = 3'd4;
	localparam logic [2:0] MS_MIX2 = 3'd5;

	// accumulator operations
	localparam logic [1:0] ACC_NONE = 2'd0;
	localparam logic [1:0] ACC_LOAD = 2'd1;
	localparam logic [1:0] ACC_ADD  = 2'd2;

	typedef struct packed {
		logic       adv;
		logic       p2;
		logic       dinc;
		logic       sinc;
		logic [1:0] job;
		logic       setup;
		logic       div;
		logic       fin;
		logic       sine_rd;
		logic       mul_en;
		logic [2:0] mul_sel;
		logic [1:0] acc_op;
		logic       out_load;
	} pbosc_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       out_busy;
	} pbosc_stat_t;

	typedef logic [SAMPLE_BITS-1:0] sine_lut_t [QUARTER+1];

	// long division, only used while the table is built
	function automatic logic [63:0] long_div(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r    = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// quarter-wave sine magnitude, Taylor series in Q30
	function automatic logic [SAMPLE_BITS-1:0] sine_entry(input int unsigned a);
		logic [63:0]        pi15;
		logic [63:0]        x;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic [63:0]        v;
		pi15 = 64'h3243F6A8885A308D >> 15;
		x    = (64'(a) * pi15) >> (TABLE_BITS + 14);
		term = x;
		sum  = $signed(x);
		for (int k = 1; k <= 7; k++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = long_div(term, 64'(2 * k) * 64'(2 * k + 1));
			if ((k & 1) != 0)
				sum = sum - $signed(term);
			else
				sum = sum + $signed(term);
		end
		if (sum < 0)
			sum = 64'sd0;
		v = (($unsigned(sum) << SFRAC) + (64'd1 << 29)) >> 30;
		return v[SAMPLE_BITS-1:0];
	endfunction

	function automatic sine_lut_t build_sine_lut();
		sine_lut_t t;
		for (int i = 0; i <= QUARTER; i++)
			t[i] = sine_entry(i);
		return t;
	endfunction

	localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

// ===== hw/rtl/pbosc_ctrl.sv =====
// Sequencer that steps one sample tick through the shared datapath.
`timescale 1ns / 1ps
module pbosc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pbosc_pkg::pbosc_stat_t stat,
	output pbosc_pkg::pbosc_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_P2    = 4'd1;
	localparam logic [3:0] S_DINC  = 4'd2;
	localparam logic [3:0] S_SINC  = 4'd3;
	localparam logic [3:0] S_SETUP = 4'd4;
	localparam logic [3:0] S_DIV   = 4'd5;
	localparam logic [3:0] S_SQR   = 4'd6;
	localparam logic [3:0] S_FIN   = 4'd7;
	localparam logic [3:0] S_SINE  = 4'd8;
	localparam logic [3:0] S_MIX0  = 4'd9;
	localparam logic [3:0] S_MIX1  = 4'd10;
	localparam logic [3:0] S_MIX2  = 4'd11;
	localparam logic [3:0] S_MIX3  = 4'd12;
	localparam logic [3:0] S_OUT   = 4'd13;

	logic [3:0]                  state_q, state_d;
	logic [1:0]                  job_q, job_d;
	logic [pbosc_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0]                  last_job;

	always_comb begin
		case (stat.mode)
			pbosc_pkg::MODE_SAW:   last_job = pbosc_pkg::JOB_MAIN;
			pbosc_pkg::MODE_PULSE: last_job = pbosc_pkg::JOB_SHIFT;
			default:               last_job = pbosc_pkg::JOB_SUB;
		endcase
	end

	always_comb begin
		state_d     = state_q;
		job_d       = job_q;
		cnt_d       = cnt_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.job     = job_q;
		cmd.mul_sel = pbosc_pkg::MS_DET;
		cmd.acc_op  = pbosc_pkg::ACC_NONE;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				job_d    = pbosc_pkg::JOB_MAIN;
				if (in_valid) begin
					cmd.adv = 1'b1;
					case (stat.mode)
						pbosc_pkg::MODE_SINE: state_d = S_SINE;
						pbosc_pkg::MODE_SAW:  state_d = S_SETUP;
						default:              state_d = S_P2;
					endcase
				end
			end
			S_P2: begin
				cmd.p2      = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pbosc_pkg::MS_DET;
				state_d = (stat.mode == pbosc_pkg::MODE_EXTREME) ? S_DINC : S_SETUP;
			end
			S_DINC: begin
				cmd.dinc    = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pbosc_pkg::MS_SUB;
				state_d     = S_SINC;
			end
			S_SINC: begin
				cmd.sinc = 1'b1;
				state_d  = S_SETUP;
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				cnt_d     = '0;
				state_d   = S_DIV;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == pbosc_pkg::CNT_W'(pbosc_pkg::TQ))
					state_d = S_SQR;
			end
			S_SQR: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pbosc_pkg::MS_SQR;
				state_d     = S_FIN;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				if (job_q == last_job) begin
					state_d = (stat.mode == pbosc_pkg::MODE_EXTREME) ? S_MIX0 : S_OUT;
				end else begin
					job_d   = job_q + 1'b1;
					state_d = S_SETUP;
				end
			end
			S_SINE: begin
				cmd.sine_rd = 1'b1;
				state_d     = S_OUT;
			end
			S_MIX0: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pbosc_pkg::MS_MIX0;
				state_d     = S_MIX1;
			end
			S_MIX1: begin
				cmd.acc_op  = pbosc_pkg::ACC_LOAD;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pbosc_pkg::MS_MIX1;
				state_d     = S_MIX2;
			end
			S_MIX2: begin
				cmd.acc_op  = pbosc_pkg::ACC_ADD;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pbosc_pkg::MS_MIX2;
				state_d     = S_MIX3;
			end
			S_MIX3: begin
				cmd.acc_op = pbosc_pkg::ACC_ADD;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			job_q   <= pbosc_pkg::JOB_MAIN;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
			cnt_q   <= cnt_d;
		end
	end

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> cnt_q <= pbosc_pkg::CNT_W'(pbosc_pkg::TQ))
		else $error("divide count overran");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !stat.out_busy)
		else $error("output loaded while occupied");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> state_q == S_IDLE)
		else $error("sequencer did not return to idle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q != S_IDLE)
		else $error("accepted beat left sequencer idle");

endmodule

// ===== hw/rtl/pbosc_dp.sv =====
// Datapath: config registers, phases, divider, shared multiplier, mixer, output register.
`timescale 1ns / 1ps
module pbosc_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pbosc_pkg::pbosc_cmd_t                 cmd,
	output pbosc_pkg::pbosc_stat_t                stat,
	input  logic [pbosc_pkg::PH_BITS-1:0]         phase_step,
	input  logic                                  cfg_valid,
	input  logic [pbosc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pbosc_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [pbosc_pkg::SAMPLE_BITS-1:0] sample_out
);

	localparam int PH  = pbosc_pkg::PH_BITS;
	localparam int SW  = pbosc_pkg::SW;
	localparam int MW  = pbosc_pkg::MW;
	localparam int PW  = pbosc_pkg::PW;
	localparam int AW  = pbosc_pkg::ACC_W;
	localparam int QW  = pbosc_pkg::QW;
	localparam int TB  = pbosc_pkg::TABLE_BITS;
	localparam int SB  = pbosc_pkg::SAMPLE_BITS;
	localparam int SF  = pbosc_pkg::SFRAC;
	localparam logic [PH:0] WRAP = {1'b1, {PH{1'b0}}};

	// configuration registers
	logic [1:0]                        wave_mode_q;
	logic [PH-1:0]                     pulse_thr_q;
	logic [15:0]                       pulse_offset_q;
	logic [pbosc_pkg::GAIN_W-1:0]      saw_gain_q, pulse_gain_q, sub_gain_q;
	logic [pbosc_pkg::RATIO_W-1:0]     detune_ratio_q, sub_ratio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_mode_q    <= pbosc_pkg::MODE_SAW;
			pulse_thr_q    <= PH'(67108864);
			pulse_offset_q <= '0;
			saw_gain_q     <= '0;
			pulse_gain_q   <= '0;
			sub_gain_q     <= '0;
			detune_ratio_q <= pbosc_pkg::RATIO_W'(65536);
			sub_ratio_q    <= pbosc_pkg::RATIO_W'(32768);
		end else if (cfg_valid) begin
			case (cfg_index)
				pbosc_pkg::REG_WAVE_MODE:    wave_mode_q    <= cfg_data[1:0];
				pbosc_pkg::REG_PULSE_THR:    pulse_thr_q    <= cfg_data[PH-1:0];
				pbosc_pkg::REG_PULSE_OFFSET: pulse_offset_q <= cfg_data[15:0];
				pbosc_pkg::REG_SAW_GAIN:     saw_gain_q     <= cfg_data[15:0];
				pbosc_pkg::REG_PULSE_GAIN:   pulse_gain_q   <= cfg_data[15:0];
				pbosc_pkg::REG_SUB_GAIN:     sub_gain_q     <= cfg_data[15:0];
				pbosc_pkg::REG_DETUNE_RATIO: detune_ratio_q <= cfg_data[pbosc_pkg::RATIO_W-1:0];
				pbosc_pkg::REG_SUB_RATIO:    sub_ratio_q    <= cfg_data[pbosc_pkg::RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	// phases and increments
	logic [PH-1:0] main_phase_q, detune_phase_q, sub_phase_q, p2_q;
	logic [PH-1:0] inc_q, dinc_q, sinc_q;
	logic signed [PW-1:0] mul_q;
	logic [PH-1:0] scaled_inc;
	logic [PH:0]   main_sum, p2_sum, det_sum, sub_sum;

	assign scaled_inc = (|mul_q[PW-1:PH+16]) ? {PH{1'b1}} : mul_q[PH+15:16];
	assign main_sum   = {1'b0, main_phase_q} + {1'b0, phase_step};
	assign p2_sum     = {1'b0, main_phase_q} + {1'b0, pulse_thr_q};
	assign det_sum    = {1'b0, detune_phase_q} + {1'b0, scaled_inc};
	assign sub_sum    = {1'b0, sub_phase_q} + {1'b0, scaled_inc};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_phase_q   <= '0;
			detune_phase_q <= '0;
			sub_phase_q    <= '0;
		end else begin
			if (cmd.adv)
				main_phase_q <= main_sum[PH-1:0];
			if (cmd.dinc)
				detune_phase_q <= det_sum[PH-1:0];
			if (cmd.sinc)
				sub_phase_q <= sub_sum[PH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.adv)
			inc_q <= phase_step;
		if (cmd.p2)
			p2_q <= p2_sum[PH-1:0];
		if (cmd.dinc)
			dinc_q <= scaled_inc;
		if (cmd.sinc)
			sinc_q <= scaled_inc;
	end

	// saw job: ramp value, BLEP region, divider
	logic [PH-1:0]        ph_sel, ic_sel, num;
	logic [PH:0]          job_sum;
	logic                 lo, hi;
	logic [47:0]          ramp;
	logic signed [SW-1:0] base;

	always_comb begin
		case (cmd.job)
			pbosc_pkg::JOB_MAIN:   begin ph_sel = main_phase_q;   ic_sel = inc_q;  end
			pbosc_pkg::JOB_SHIFT:  begin ph_sel = p2_q;           ic_sel = inc_q;  end
			pbosc_pkg::JOB_DETUNE: begin ph_sel = detune_phase_q; ic_sel = dinc_q; end
			default:               begin ph_sel = sub_phase_q;    ic_sel = sinc_q; end
		endcase
	end

	assign job_sum = {1'b0, ph_sel} + {1'b0, ic_sel};
	assign lo      = ph_sel < ic_sel;
	assign hi      = job_sum > WRAP;
	assign num     = lo ? (ic_sel - ph_sel) : job_sum[PH-1:0];
	assign ramp    = (48'(ph_sel[PH-1:pbosc_pkg::FRAC_BITS]) << (SF + 1)) >> TB;
	assign base    = $signed(ramp[SW-1:0]) - $signed(SW'(1 << SF));

	logic [PH+1:0]        div_r_q;
	logic [PH-1:0]        div_d_q;
	logic [QW-1:0]        div_q_q;
	logic signed [SW-1:0] base_q;
	logic                 add_q, sub_q;
	logic [PH+1:0]        div_diff;

	assign div_diff = div_r_q - {2'b00, div_d_q};

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			div_r_q <= {2'b00, num};
			div_d_q <= ic_sel;
			div_q_q <= '0;
			base_q  <= base;
			add_q   <= lo;
			sub_q   <= !lo && hi;
		end else if (cmd.div) begin
			if (div_r_q >= {2'b00, div_d_q}) begin
				div_q_q <= {div_q_q[QW-2:0], 1'b1};
				div_r_q <= {div_diff[PH:0], 1'b0};
			end else begin
				div_q_q <= {div_q_q[QW-2:0], 1'b0};
				div_r_q <= {div_r_q[PH:0], 1'b0};
			end
		end
	end

	// BLEP square, rounded
	logic [PW-1:0]        corr_w;
	logic signed [SW-1:0] corr;
	logic signed [SW-1:0] saw_q [4];

	assign corr_w = ($unsigned(mul_q) + (PW'(1) << (47 - SF))) >> (48 - SF);
	assign corr   = $signed(corr_w[SW-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			if (add_q)
				saw_q[cmd.job] <= base_q + corr;
			else if (sub_q)
				saw_q[cmd.job] <= base_q - corr;
			else
				saw_q[cmd.job] <= base_q;
		end
	end

	// pulse and mix operands
	logic signed [AW-1:0] off_w;
	logic signed [SW+1:0] pulse;
	logic signed [SW:0]   saw_pair;

	assign off_w    = (AW'($signed(pulse_offset_q)) <<< SF) >>> 15;
	assign pulse    = (SW+2)'(saw_q[0]) - (SW+2)'(saw_q[1]) - off_w[SW+1:0];
	assign saw_pair = (SW+1)'(saw_q[0]) + (SW+1)'(saw_q[2]);

	// shared multiplier
	logic signed [MW-1:0] ma, mb;

	always_comb begin
		case (cmd.mul_sel)
			pbosc_pkg::MS_DET: begin
				ma = $signed(MW'(inc_q));
				mb = $signed(MW'(detune_ratio_q));
			end
			pbosc_pkg::MS_SUB: begin
				ma = $signed(MW'(inc_q));
				mb = $signed(MW'(sub_ratio_q));
			end
			pbosc_pkg::MS_SQR: begin
				ma = $signed(MW'(div_q_q));
				mb = $signed(MW'(div_q_q));
			end
			pbosc_pkg::MS_MIX0: begin
				ma = MW'(saw_pair);
				mb = $signed(MW'(saw_gain_q));
			end
			pbosc_pkg::MS_MIX1: begin
				ma = MW'(pulse);
				mb = $signed(MW'(pulse_gain_q));
			end
			default: begin
				ma = MW'(saw_q[3]);
				mb = $signed(MW'(sub_gain_q));
			end
		endcase
	end

	logic signed [AW-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			mul_q <= ma * mb;
		case (cmd.acc_op)
			pbosc_pkg::ACC_LOAD: acc_q <= mul_q[AW-1:0];
			pbosc_pkg::ACC_ADD:  acc_q <= acc_q + mul_q[AW-1:0];
			default: ;
		endcase
	end

	// sine table read, quarter-wave folded
	logic [TB-1:0]          sidx;
	logic [TB-1:0]          sfold;
	logic [pbosc_pkg::QA_W-1:0] saddr;
	logic [SB-1:0]          sine_q;
	logic                   sneg_q;

	assign sidx  = main_phase_q[PH-1:pbosc_pkg::FRAC_BITS];
	assign sfold = TB'(pbosc_pkg::HALF) - {1'b0, sidx[TB-2:0]};
	assign saddr = ({1'b0, sidx[TB-2:0]} <= TB'(pbosc_pkg::QUARTER)) ?
		sidx[TB-2:0] : sfold[TB-2:0];

	always_ff @(posedge clk) begin
		if (cmd.sine_rd) begin
			sine_q <= pbosc_pkg::SINE_LUT[saddr];
			sneg_q <= sidx[TB-1];
		end
	end

	// final value and saturation
	logic signed [AW-1:0] vsel, mixed;
	logic signed [SB-1:0] vsat;

	assign mixed = (acc_q + AW'(32768)) >>> 16;

	always_comb begin
		case (wave_mode_q)
			pbosc_pkg::MODE_SINE:
				vsel = sneg_q ? -$signed(AW'(sine_q)) : $signed(AW'(sine_q));
			pbosc_pkg::MODE_SAW:   vsel = AW'(saw_q[0]);
			pbosc_pkg::MODE_PULSE: vsel = AW'(pulse);
			default:               vsel = mixed;
		endcase
		if (vsel > $signed(AW'((1 << SF) - 1)))
			vsat = {1'b0, {SF{1'b1}}};
		else if (vsel < -$signed(AW'(1 << SF)))
			vsat = {1'b1, {SF{1'b0}}};
		else
			vsat = vsel[SB-1:0];
	end

	logic out_valid_q;
	logic signed [SB-1:0] sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			sample_q <= vsat;
	end

	assign out_valid     = out_valid_q;
	assign sample_out    = sample_q;
	assign stat.mode     = wave_mode_q;
	assign stat.out_busy = out_valid_q && !out_ready;

endmodule

// ===== hw/rtl/polyblep_phase_accumulator_oscillator_core.sv =====
// Top level of the polyBLEP phase-accumulator oscillator.
`timescale 1ns / 1ps
// Band-limited oscillator: one signed sample per input beat.
// Input channel (in_valid/in_ready, phase_step): each beat is one sample
// tick carrying the main phase increment. Output channel (out_valid/out_ready,
// sample_out): one saturated sample per input beat, in order.
// Config channel (cfg_valid/cfg_ready, cfg_index/cfg_data): always ready;
// write only while the block is idle. Unknown indexes are dropped.
// Timing: one beat at a time through a sequencer and a shared datapath.
// Each saw evaluation steps through setup, the 25-step restoring divider
// that forms the BLEP ratio, the square and the finish. Sine reads the
// table; saw runs one evaluation, pulse two, extreme four and then the mix.
// After the sample is loaded into the output register, the sequencer is
// ready for the next beat in the cycle after that load.
// A stalled receiver holds the result register and the sequencer waits in
// its output step with the next sample, and the input stays blocked.
// Reset clears all three phases, loads the register defaults (saw mode,
// half-table pulse threshold, unity detune, half-rate sub) and empties the
// output register.
module polyblep_phase_accumulator_oscillator_core (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [pbosc_pkg::PH_BITS-1:0]            phase_step,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [pbosc_pkg::SAMPLE_BITS-1:0] sample_out,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [pbosc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [pbosc_pkg::CFG_DATA_W-1:0]         cfg_data
);

	pbosc_pkg::pbosc_cmd_t  cmd;
	pbosc_pkg::pbosc_stat_t stat;

	// config writes are always accepted and land in the configuration registers
	assign cfg_ready = 1'b1;

	pbosc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pbosc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.phase_step (phase_step),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out)
	);

endmodule
